// ===== src/pcbel_pkg.sv =====
// Package for the per-consumer button edge latch.
// Holds widths, default sizes, action codes and the controller state type.
// No dependencies.
`default_nettype none

package pcbel_pkg;

	// Default sizes
	localparam int NUM_BUTTONS_DEF = 8;
	localparam int NUM_SLOTS_DEF   = 8;

	// Field widths
	localparam int ACTION_W = 2;
	localparam int BUTTON_W = 8;
	localparam int SLOT_W   = 4;
	localparam int GEN_W    = 32;

	// Action codes
	localparam logic [ACTION_W-1:0] ACT_DOWN      = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_UP        = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_Q_PRESS   = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_Q_RELEASE = 2'd3;

	// Controller states
	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EXEC  = 3'b100
	} state_t;

endpackage

`default_nettype wire

// ===== src/pcbel_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the generation and seen-state stores. No dependencies.
`default_nettype none

module pcbel_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== src/per_consumer_button_edge_latch.sv =====
// Top level of the per-consumer button edge latch.
// Depends on pcbel_pkg and pcbel_ram (generation store and seen store).
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------
//   in      | input     | in_valid / in_stall  | action, button, slot, epoch
//   out     | output    | out_valid / out_stall| hit
//
// Each item is a read-modify-write through the memory ports: the stores are
// read at acceptance and written back in the following cycle, and no new item
// is accepted until that write-back is done.
// After reset a clearing pass zeroes both stores; no item is accepted until
// it is done.
// A result waiting in the output register does not block the next item
// unless out_stall is high.
`default_nettype none

module per_consumer_button_edge_latch #(
	parameter int NUM_BUTTONS = pcbel_pkg::NUM_BUTTONS_DEF,
	parameter int NUM_SLOTS   = pcbel_pkg::NUM_SLOTS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [pcbel_pkg::ACTION_W-1:0] action,
	input  wire logic [pcbel_pkg::BUTTON_W-1:0] button,
	input  wire logic [pcbel_pkg::SLOT_W-1:0]   slot,
	input  wire logic [pcbel_pkg::GEN_W-1:0]    epoch,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                hit
);

	localparam int GW       = pcbel_pkg::GEN_W;
	localparam int BTN_W    = $clog2(NUM_BUTTONS);
	localparam int SL_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_AW   = 1 + BTN_W;
	localparam int SEEN_AW  = 1 + SL_W + BTN_W;
	localparam int CNT_DEP  = 1 << CNT_AW;
	localparam int SEEN_DEP = 1 << SEEN_AW;
	localparam logic [pcbel_pkg::BUTTON_W:0] BTN_LIM = (pcbel_pkg::BUTTON_W+1)'(NUM_BUTTONS);
	localparam logic [pcbel_pkg::SLOT_W:0]   SLOT_LIM = (pcbel_pkg::SLOT_W+1)'(NUM_SLOTS);

	pcbel_pkg::state_t state_q;
	logic [SEEN_AW-1:0] clr_addr_q;

	logic in_acc;
	logic is_event, btn_ok, slot_ok;

	logic              ev_s1, btn_ok_s1, slot_ok_s1;
	logic [GW-1:0]     epoch_s1;
	logic [CNT_AW-1:0] cnt_addr_s1;
	logic [SEEN_AW-1:0] seen_addr_s1;

	logic [CNT_AW-1:0]  cnt_raddr;
	logic [SEEN_AW-1:0] seen_raddr;
	logic [GW-1:0]      cnt_rdata;
	logic [2*GW-1:0]    seen_rdata;

	logic               cnt_we, seen_we;
	logic [CNT_AW-1:0]  cnt_waddr;
	logic [SEEN_AW-1:0] seen_waddr;
	logic [GW-1:0]      cnt_wdata;
	logic [2*GW-1:0]    seen_wdata;

	logic          exec;
	logic [GW-1:0] gen, gen_next, seen_gen, seen_epoch;
	logic          q_ok, resync, new_hit, ev_we, q_we;

	logic out_valid_q, hit_q;

	// Input decode
	assign in_stall = (state_q != pcbel_pkg::ST_IDLE) || (out_valid_q && out_stall);
	assign in_acc   = in_valid && !in_stall;
	assign is_event = (action == pcbel_pkg::ACT_DOWN) || (action == pcbel_pkg::ACT_UP);
	assign btn_ok   = (button != '0) && ({1'b0, button} < BTN_LIM);
	assign slot_ok  = {1'b0, slot} < SLOT_LIM;

	// Read addresses: low action bit picks press or release
	assign cnt_raddr  = {action[0], button[BTN_W-1:0]};
	assign seen_raddr = {action[0], slot[SL_W-1:0], button[BTN_W-1:0]};

	// Item register for the write-back cycle
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ev_s1        <= is_event;
			btn_ok_s1    <= btn_ok;
			slot_ok_s1   <= slot_ok;
			epoch_s1     <= epoch;
			cnt_addr_s1  <= cnt_raddr;
			seen_addr_s1 <= seen_raddr;
		end
	end

	// Generation advance and edge check
	assign exec       = (state_q == pcbel_pkg::ST_EXEC);
	assign gen        = cnt_rdata;
	assign gen_next   = (&gen) ? GW'(1) : gen + GW'(1);
	assign seen_gen   = seen_rdata[GW-1:0];
	assign seen_epoch = seen_rdata[2*GW-1:GW];
	assign q_ok       = exec && !ev_s1 && btn_ok_s1 && slot_ok_s1;
	assign resync     = seen_epoch != epoch_s1;
	assign new_hit    = !resync && (gen != '0) && (seen_gen != gen);
	assign ev_we      = exec && ev_s1 && btn_ok_s1;
	assign q_we       = q_ok && (resync || new_hit);

	// Write port mux: clearing pass or write-back
	always_comb begin
		if (state_q == pcbel_pkg::ST_CLEAR) begin
			cnt_we     = 1'b1;
			cnt_waddr  = clr_addr_q[CNT_AW-1:0];
			cnt_wdata  = '0;
			seen_we    = 1'b1;
			seen_waddr = clr_addr_q;
			seen_wdata = '0;
		end else begin
			cnt_we     = ev_we;
			cnt_waddr  = cnt_addr_s1;
			cnt_wdata  = gen_next;
			seen_we    = q_we;
			seen_waddr = seen_addr_s1;
			seen_wdata = {epoch_s1, gen};
		end
	end

	pcbel_ram #(.WIDTH(GW), .DEPTH(CNT_DEP)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	pcbel_ram #(.WIDTH(2*GW), .DEPTH(SEEN_DEP)) u_seen_ram (
		.clk   (clk),
		.we    (seen_we),
		.waddr (seen_waddr),
		.wdata (seen_wdata),
		.raddr (seen_raddr),
		.rdata (seen_rdata)
	);

	// Controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pcbel_pkg::ST_CLEAR;
			clr_addr_q <= '0;
		end else begin
			unique case (state_q)
				pcbel_pkg::ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + SEEN_AW'(1);
					if (&clr_addr_q) begin
						state_q <= pcbel_pkg::ST_IDLE;
					end
				end
				pcbel_pkg::ST_IDLE: begin
					if (in_acc) begin
						state_q <= pcbel_pkg::ST_EXEC;
					end
				end
				pcbel_pkg::ST_EXEC: begin
					state_q <= pcbel_pkg::ST_IDLE;
				end
				default: begin
					state_q <= pcbel_pkg::ST_CLEAR;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			hit_q <= q_ok && new_hit;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;

	// Checks
	a_no_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pcbel_pkg::ST_CLEAR) |-> !in_acc)
		else $error("item accepted during clearing pass");

	a_acc_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == pcbel_pkg::ST_EXEC))
		else $error("accepted item not followed by write-back");

	a_exec_out: assert property (@(posedge clk) disable iff (!arst_n)
		exec |=> out_valid_q)
		else $error("write-back produced no result");

	a_we_excl: assert property (@(posedge clk) disable iff (!arst_n)
		exec |-> !(cnt_we && seen_we))
		else $error("event and query write-back in the same cycle");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> in_stall)
		else $error("item accepted while result is held");

endmodule

`default_nettype wire
